@@ hw/rtl/mm4_pkg.sv @@
`timescale 1ns / 1ps

package mm4_pkg;

	localparam int VALUE_WIDTH   = 32;
	localparam int FRACTION_BITS = 16;
	localparam int PROD_W        = 2 * VALUE_WIDTH;
	// four products summed need two more bits
	localparam int ACC_W         = PROD_W + 2;
	localparam int MAT_N         = 4;
	localparam int K_W           = $clog2(MAT_N);
	localparam int IDX_W         = 2 * K_W;
	localparam int CNT_W         = IDX_W + 1;

	localparam logic [CNT_W-1:0] LOAD_LAST = CNT_W'(2 * MAT_N * MAT_N - 1);
	localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(MAT_N * MAT_N - 1);
	localparam logic [K_W-1:0]   K_LAST    = K_W'(MAT_N - 1);

	typedef struct packed {
		logic             wr_left;
		logic             wr_right;
		logic [IDX_W-1:0] wr_addr;
		logic             rd;
		logic             first;
		logic             last;
		logic [K_W-1:0]   k;
		logic [IDX_W-1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic taken;
	} status_t;

	function automatic logic [VALUE_WIDTH-1:0] saturate(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-1:0]       sh;
		logic [ACC_W-VALUE_WIDTH:0]    top;
		logic [VALUE_WIDTH-1:0]        res;
		sh  = acc >>> FRACTION_BITS;
		top = sh[ACC_W-1:VALUE_WIDTH-1];
		if ((&top) || (~|top)) begin
			res = sh[VALUE_WIDTH-1:0];
		end else if (sh[ACC_W-1]) begin
			res = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
		end else begin
			res = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
		end
		return res;
	endfunction

endpackage

@@ hw/rtl/mm4_ram.sv @@
`timescale 1ns / 1ps

module mm4_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/mm4_ctrl.sv @@
`timescale 1ns / 1ps

module mm4_ctrl
	import mm4_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	localparam logic [1:0] ST_LOAD = 2'd0;
	localparam logic [1:0] ST_CALC = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [K_W-1:0]   k_q;
	logic [IDX_W-1:0] idx_q;
	logic             accept;

	assign in_ready = (state_q == ST_LOAD);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd          = '0;
		cmd.wr_left  = accept && !cnt_q[CNT_W-1];
		cmd.wr_right = accept && cnt_q[CNT_W-1];
		cmd.wr_addr  = cnt_q[IDX_W-1:0];
		cmd.rd       = (state_q == ST_CALC);
		cmd.first    = (k_q == '0);
		cmd.last     = (k_q == K_LAST);
		cmd.k        = k_q;
		cmd.idx      = idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
			k_q     <= '0;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (accept) begin
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == LOAD_LAST) begin
							state_q <= ST_CALC;
							k_q     <= '0;
							idx_q   <= '0;
						end
					end
				end
				ST_CALC: begin
					k_q <= k_q + 1'b1;
					if (k_q == K_LAST) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					// next element only once the output register is free
					if (status.taken) begin
						idx_q <= idx_q + 1'b1;
						state_q <= (idx_q == IDX_LAST) ? ST_LOAD : ST_CALC;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

@@ hw/rtl/mm4_datapath.sv @@
`timescale 1ns / 1ps

module mm4_datapath
	import mm4_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  cmd_t                          cmd,
	output status_t                       status,
	input  logic signed [VALUE_WIDTH-1:0] element,
	output logic signed [VALUE_WIDTH-1:0] product_element,
	output logic [IDX_W-1:0]              product_index,
	output logic                          last,
	output logic                          out_valid,
	input  logic                          out_ready
);

	logic [VALUE_WIDTH-1:0]   rdata_a;
	logic [VALUE_WIDTH-1:0]   rdata_b;
	logic [IDX_W-1:0]         raddr_a;
	logic [IDX_W-1:0]         raddr_b;

	logic                     rd_s1, first_s1, last_s1;
	logic [IDX_W-1:0]         idx_s1;
	logic                     rd_s2, first_s2, last_s2;
	logic [IDX_W-1:0]         idx_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  prod_ext;
	logic                     done_s3;
	logic [IDX_W-1:0]         idx_s3;

	logic                     out_valid_q;
	logic [VALUE_WIDTH-1:0]   out_elem_q;
	logic [IDX_W-1:0]         out_idx_q;
	logic                     out_last_q;

	// a[r + 4k] and b[k + 4c]
	assign raddr_a = {cmd.k, cmd.idx[K_W-1:0]};
	assign raddr_b = {cmd.idx[IDX_W-1:K_W], cmd.k};

	mm4_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(MAT_N * MAT_N)) u_left_ram (
		.clk   (clk),
		.we    (cmd.wr_left),
		.waddr (cmd.wr_addr),
		.wdata (element),
		.raddr (raddr_a),
		.rdata (rdata_a)
	);

	mm4_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(MAT_N * MAT_N)) u_right_ram (
		.clk   (clk),
		.we    (cmd.wr_right),
		.waddr (cmd.wr_addr),
		.wdata (element),
		.raddr (raddr_b),
		.rdata (rdata_b)
	);

	assign prod_ext = {{(ACC_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1       <= 1'b0;
			rd_s2       <= 1'b0;
			done_s3     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_s1   <= cmd.rd;
			rd_s2   <= rd_s1;
			done_s3 <= rd_s2 && last_s2;
			if (done_s3) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= cmd.first;
		last_s1  <= cmd.last;
		idx_s1   <= cmd.idx;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		idx_s2   <= idx_s1;
		prod_s2  <= $signed(rdata_a) * $signed(rdata_b);
		if (rd_s2) begin
			acc_q <= first_s2 ? prod_ext : acc_q + prod_ext;
		end
		idx_s3 <= idx_s2;
		if (done_s3) begin
			out_elem_q <= saturate(acc_q);
			out_idx_q  <= idx_s3;
			out_last_q <= (idx_s3 == IDX_LAST);
		end
	end

	assign status.taken    = out_valid_q && out_ready;
	assign out_valid       = out_valid_q;
	assign product_element = out_elem_q;
	assign product_index   = out_idx_q;
	assign last            = out_last_q;

endmodule

@@ hw/rtl/matrix4x4_multiply.sv @@
`timescale 1ns / 1ps

// 4x4 matrix multiply, column-major, signed Q16.16. Send the 16 elements of A
// and then the 16 of B on the input channel, index = row + 4*column; the
// block takes one element per cycle while loading. It then returns the 16
// elements of C = A*B in index order, with last set on the final one. The
// four products of each element are summed at full width, and the sum is
// shifted right by 16 and saturated. One shared multiply-accumulate unit
// reads one A and one B element a cycle from two small RAMs while computing;
// the next element is computed only after the previous result is taken. No
// input is taken while results are being produced.

module matrix4x4_multiply
	import mm4_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic signed [VALUE_WIDTH-1:0] element,
	input  logic                          in_valid,
	output logic                          in_ready,
	output logic signed [VALUE_WIDTH-1:0] product_element,
	output logic [IDX_W-1:0]              product_index,
	output logic                          last,
	output logic                          out_valid,
	input  logic                          out_ready
);

	cmd_t    cmd;
	status_t status;

	mm4_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	mm4_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.element         (element),
		.product_element (product_element),
		.product_index   (product_index),
		.last            (last),
		.out_valid       (out_valid),
		.out_ready       (out_ready)
	);

`ifndef SYNTHESIS
	// loading and result delivery never overlap
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while a result is pending");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last) |-> (product_index == IDX_LAST))
		else $error("last flag on wrong product index");

	// taking the final result reopens the input
	a_reload: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last) |=> in_ready)
		else $error("input not reopened after last result");

	a_no_rd_in_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !cmd.rd)
		else $error("read issued while loading");
`endif

endmodule

@@ tb/tb_matrix4x4_multiply.sv @@
`timescale 1ns / 1ps

module tb_matrix4x4_multiply
	import mm4_pkg::*;
();

	localparam int SUM_W      = 2 * VALUE_WIDTH + 2;
	localparam int IDLE_LIMIT = 3000;
	localparam int DRAIN_WAIT = 40;
	localparam int HOLD_LEN   = 400;
	localparam int RANDOM_RUNS = 4;

	localparam logic signed [SUM_W-1:0] Q_MAX = SUM_W'(64'sh7FFFFFFF);
	localparam logic signed [SUM_W-1:0] Q_MIN = -SUM_W'(64'sh80000000);

	localparam logic [VALUE_WIDTH-1:0] E_MAX  = 32'h7FFF_FFFF;
	localparam logic [VALUE_WIDTH-1:0] E_MIN  = 32'h8000_0000;
	localparam logic [VALUE_WIDTH-1:0] E_ONE  = 32'h0001_0000;
	localparam logic [VALUE_WIDTH-1:0] E_MONE = 32'hFFFF_0000;

	typedef enum int {
		RUN_ALL_MAX,
		RUN_MIN_MAX,
		RUN_MIN_MIN,
		RUN_IDENTITY_EXTREMES,
		RUN_WIDE,
		RUN_SMALL,
		RUN_EDGE,
		RUN_NEAR_LIMIT
	} run_kind_t;

	typedef struct {
		logic signed [VALUE_WIDTH-1:0] value;
		logic [IDX_W-1:0]              index;
		logic                          tail;
	} product_t;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic signed [VALUE_WIDTH-1:0] element   = '0;
	logic                          in_valid  = 1'b0;
	logic                          in_ready;
	logic signed [VALUE_WIDTH-1:0] product_element;
	logic [IDX_W-1:0]              product_index;
	logic                          last;
	logic                          out_valid;
	logic                          out_ready = 1'b0;

	logic [VALUE_WIDTH-1:0] pending_elements[$];
	product_t               expected_products[$];

	logic signed [VALUE_WIDTH-1:0] left_mat[16];
	logic signed [VALUE_WIDTH-1:0] right_mat[16];
	int load_pos;

	int mismatches;
	int products_checked;
	int runs_queued;
	int burst_left;
	int gap_left;
	int rx_cycle;
	int rx_taken;
	int hold_left;
	bit hold_done;
	int idle_cycles;

	matrix4x4_multiply dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.element         (element),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.product_element (product_element),
		.product_index   (product_index),
		.last            (last),
		.out_valid       (out_valid),
		.out_ready       (out_ready)
	);

	always #10 clk = ~clk;

	// one dot product of row r of A and column c of B, full width, then saturated
	function automatic logic signed [VALUE_WIDTH-1:0] dot_q16(input int r, input int c);
		logic signed [SUM_W-1:0]         acc;
		logic signed [2*VALUE_WIDTH-1:0] prod;
		logic signed [2*VALUE_WIDTH-1:0] a_ext;
		logic signed [2*VALUE_WIDTH-1:0] b_ext;
		acc = '0;
		for (int k = 0; k < 4; k++) begin
			a_ext = {{VALUE_WIDTH{left_mat[r + 4 * k][VALUE_WIDTH-1]}}, left_mat[r + 4 * k]};
			b_ext = {{VALUE_WIDTH{right_mat[k + 4 * c][VALUE_WIDTH-1]}}, right_mat[k + 4 * c]};
			prod  = a_ext * b_ext;
			acc   = acc + SUM_W'(prod);
		end
		acc = acc >>> FRACTION_BITS;
		if (acc > Q_MAX) begin
			return E_MAX;
		end else if (acc < Q_MIN) begin
			return E_MIN;
		end
		return acc[VALUE_WIDTH-1:0];
	endfunction

	task automatic absorb_element(input logic signed [VALUE_WIDTH-1:0] v);
		product_t p;
		if (load_pos < 16) begin
			left_mat[load_pos] = v;
		end else begin
			right_mat[load_pos - 16] = v;
		end
		if (load_pos == 31) begin
			load_pos = 0;
			for (int idx = 0; idx < 16; idx++) begin
				p.value = dot_q16(idx % 4, idx / 4);
				p.index = IDX_W'(idx);
				p.tail  = (idx == 15);
				expected_products.push_back(p);
			end
		end else begin
			load_pos++;
		end
	endtask

	function automatic logic [VALUE_WIDTH-1:0] make_element(input run_kind_t kind, input int pos);
		int mag;
		case (kind)
			RUN_ALL_MAX: return E_MAX;
			RUN_MIN_MAX: return (pos < 16) ? E_MIN : E_MAX;
			RUN_MIN_MIN: return E_MIN;
			RUN_IDENTITY_EXTREMES: begin
				// A is the identity, so C comes back equal to B
				if (pos < 16) begin
					return (pos % 5 == 0) ? E_ONE : '0;
				end
				case (pos - 16)
					0: return E_MAX;
					1: return E_MIN;
					2: return '0;
					3: return '1;
					4: return 32'h0000_0001;
					5: return E_ONE;
					6: return E_MONE;
					7: return 32'h5555_AAAA;
					default: return $urandom;
				endcase
			end
			RUN_WIDE: return $urandom;
			RUN_SMALL: return VALUE_WIDTH'($urandom_range(0, (1 << 19) - 1) - (1 << 18));
			RUN_EDGE: begin
				case ($urandom_range(0, 7))
					0: return E_MAX;
					1: return E_MIN;
					2: return '0;
					3: return '1;
					4: return 32'h0000_0001;
					5: return E_ONE;
					6: return E_MONE;
					default: return $urandom;
				endcase
			end
			default: begin
				// products near 2^44..2^48, sums straddle the saturation limit
				mag = $urandom_range(1 << 22, 1 << 24);
				return VALUE_WIDTH'($urandom_range(0, 1) ? -mag : mag);
			end
		endcase
	endfunction

	task automatic queue_run(input run_kind_t kind);
		for (int i = 0; i < 32; i++) begin
			pending_elements.push_back(make_element(kind, i));
		end
		runs_queued++;
	endtask

	// request driver: bursts of random length with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			element    <= '0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			if (in_valid && in_ready) begin
				absorb_element(element);
				void'(pending_elements.pop_front());
			end
			if (!in_valid || in_ready) begin
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_elements.size() != 0) begin
					in_valid <= 1'b1;
					element  <= pending_elements[0];
					if (burst_left <= 1) begin
						if ($urandom_range(0, 4) == 0) begin
							burst_left = 64;
							gap_left   = 0;
						end else begin
							burst_left = $urandom_range(1, 20);
							gap_left   = $urandom_range(0, 6);
						end
					end else begin
						burst_left--;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result receiver: rotating stall pattern plus one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_cycle  = 0;
			rx_taken  = 0;
			hold_left = 0;
			hold_done = 1'b0;
		end else begin
			rx_cycle++;
			if (out_valid && out_ready) begin
				rx_taken++;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (!hold_done && out_valid && rx_taken >= 40) begin
				hold_done = 1'b1;
				hold_left = HOLD_LEN;
				out_ready <= 1'b0;
			end else begin
				case ((rx_cycle / 97) % 4)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= (rx_cycle % 4 == 0);
					default: out_ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin : check_products
		product_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_products.size() == 0) begin
				$display("%0t: unexpected product index %0d value %h", $time,
					product_index, product_element);
				mismatches++;
			end else begin
				want = expected_products.pop_front();
				products_checked++;
				if (product_element !== want.value) begin
					$display("%0t: product_element idx %0d expected %h actual %h", $time,
						want.index, want.value, product_element);
					mismatches++;
				end
				if (product_index !== want.index) begin
					$display("%0t: product_index expected %0d actual %0d", $time,
						want.index, product_index);
					mismatches++;
				end
				if (last !== want.tail) begin
					$display("%0t: last idx %0d expected %b actual %b", $time,
						want.index, want.tail, last);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no handshake for %0d cycles, %0d products outstanding", $time,
					IDLE_LIMIT, expected_products.size());
				$display("matrix4x4_multiply test failed");
				$finish;
			end
		end
	end

	initial begin
		mismatches       = 0;
		products_checked = 0;
		runs_queued      = 0;
		idle_cycles      = 0;
		load_pos         = 0;

		queue_run(RUN_ALL_MAX);
		queue_run(RUN_MIN_MAX);
		queue_run(RUN_MIN_MIN);
		queue_run(RUN_IDENTITY_EXTREMES);
		for (int i = 0; i < RANDOM_RUNS; i++) begin
			queue_run(run_kind_t'($urandom_range(RUN_WIDE, RUN_NEAR_LIMIT)));
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_elements.size() != 0 || in_valid) begin
			@(posedge clk);
		end
		while (expected_products.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("covered %0d matrix pairs: saturation both ways, identity, random and near-limit",
			runs_queued);
		$display("%0d product elements checked, %0d mismatches", products_checked, mismatches);
		if (mismatches == 0) begin
			$display("matrix4x4_multiply test passed");
		end else begin
			$display("matrix4x4_multiply test failed");
		end
		$finish;
	end

endmodule
